// ----- hdl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion shorthands for the interpolator checkers
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define PLI_ASSERT_IMP(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("pli: same-cycle assertion failed");

// next-cycle implication, disabled while reset is asserted
`define PLI_ASSERT_NXT(lbl, ck, rstn, ante, cons) \
    lbl: assert property (@(posedge ck) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("pli: next-cycle assertion failed");

`endif

// ----- hdl/pli_pkg.sv -----
// ----------------------------------------------------------------------------
// pli_pkg
// shared codes, field widths and state type of the interpolator
// ----------------------------------------------------------------------------
package pli_pkg;

    // fixed field widths
    localparam int IDX_FIELD_W = 5;
    localparam int CFG_W       = 6;
    localparam int STATUS_W    = 2;

    // request kinds carried in tuser
    localparam logic REQ_LOAD  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // result status codes
    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd2;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PREP,
        ST_MUL,
        ST_DIV,
        ST_SUM,
        ST_DONE
    } pli_state_t;

endpackage

// ----- hdl/piecewise_linear_interpolator.sv -----
// ----------------------------------------------------------------------------
// piecewise_linear_interpolator
// breakpoint table with linear interpolation between neighboring entries
// ----------------------------------------------------------------------------
//  channel   direction  beat contents
//  s_axis    in         tuser: req_type; tdata: entry_index, entry_key,
//                       entry_value, query_key
//  m_axis    out        tuser: status; tdata: result_value
//  cfg       in         cfg_data: entries_used
//
//  a load or an empty-table query goes from accept straight to the done state
//  a query matching at entry i scans the table up to that entry, one table read
//  per cycle during the scan, then runs a bit-serial shift-add multiply and a
//  bit-serial restoring divide
//  reset clears control and entries_used; table contents are undefined until
//  loaded; a waiting result is held and one new beat can be taken meanwhile
// ----------------------------------------------------------------------------
module piecewise_linear_interpolator #(
    parameter int TABLE_DEPTH = 32,
    parameter int DATA_WIDTH  = 32,
    localparam int IN_BITS = pli_pkg::IDX_FIELD_W + 3 * DATA_WIDTH,
    localparam int IN_W    = ((IN_BITS + 7) / 8) * 8,
    localparam int OUT_W   = ((DATA_WIDTH + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // entry_index, entry_key, entry_value, query_key (lowest bit up)
    input  logic [IN_W-1:0]               s_axis_tdata,
    // req_type
    input  logic [0:0]                    s_axis_tuser,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // result_value
    output logic [OUT_W-1:0]              m_axis_tdata,
    // status
    output logic [pli_pkg::STATUS_W-1:0]  m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [pli_pkg::CFG_W-1:0]     cfg_data
);

    localparam int DW = DATA_WIDTH;
    localparam int EW = 2 * DATA_WIDTH;
    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);
    localparam int CW = $clog2(DATA_WIDTH);

    // input field split
    logic [pli_pkg::IDX_FIELD_W-1:0] in_index;
    logic signed [DW-1:0]            in_key;
    logic signed [DW-1:0]            in_value;
    logic signed [DW-1:0]            in_query;
    logic                            in_req;
    logic                            in_fire;
    logic                            idx_ok;
    logic                            wr_en;

    assign in_index = s_axis_tdata[pli_pkg::IDX_FIELD_W-1:0];
    assign in_key   = $signed(s_axis_tdata[pli_pkg::IDX_FIELD_W +: DW]);
    assign in_value = $signed(s_axis_tdata[pli_pkg::IDX_FIELD_W + DW +: DW]);
    assign in_query = $signed(s_axis_tdata[pli_pkg::IDX_FIELD_W + 2 * DW +: DW]);
    assign in_req   = s_axis_tuser[0];
    assign in_fire  = s_axis_tvalid && s_axis_tready;
    assign idx_ok   = 32'(in_index) < 32'(TABLE_DEPTH);
    assign wr_en    = in_fire && (in_req == pli_pkg::REQ_LOAD) && idx_ok;

    // state and control registers
    pli_pkg::pli_state_t state_reg, state_next;
    logic [pli_pkg::CFG_W-1:0] entries_used_reg;
    logic [NW-1:0]             n_reg;
    logic [NW-1:0]             n_eff;
    logic [NW-1:0]             issue_reg;
    logic [NW-1:0]             rd_idx_reg;
    logic                      rd_vld_reg;
    logic [CW-1:0]             cnt_reg;
    logic                      cnt_zero;
    logic                      out_valid_reg;
    logic                      issue_en;
    logic                      out_load;

    // datapath registers
    logic [EW-1:0]        rd_data_reg;
    logic signed [DW-1:0] query_reg;
    logic signed [DW-1:0] first_key_reg;
    logic signed [DW-1:0] first_val_reg;
    logic signed [DW-1:0] prev_key_reg;
    logic signed [DW-1:0] prev_val_reg;
    logic signed [DW-1:0] base_val_reg;
    logic signed [DW:0]   dv_reg;
    logic [DW-1:0]        den_reg;
    logic [DW-1:0]        mag_reg;
    logic                 neg_reg;
    logic [DW-1:0]        acc_reg, acc_next;
    logic [DW-1:0]        lo_reg, lo_next;
    logic [DW-1:0]        res_reg;
    logic [pli_pkg::STATUS_W-1:0] status_reg;
    logic [DW-1:0]        out_data_reg;
    logic [pli_pkg::STATUS_W-1:0] out_status_reg;

    // breakpoint table, key in the upper half of each word
    logic [EW-1:0] mem [TABLE_DEPTH];

    // clamp the entry count to the table depth
    always_comb
    begin
        if (32'(entries_used_reg) > 32'(TABLE_DEPTH))
        begin
            n_eff = NW'(TABLE_DEPTH);
        end
        else
        begin
            n_eff = NW'(entries_used_reg);
        end
    end

    // scan compare on the entry just read
    logic signed [DW-1:0] cur_key;
    logic signed [DW-1:0] cur_val;
    logic signed [DW-1:0] base_key;
    logic signed [DW-1:0] base_val;
    logic signed [DW-1:0] miss_val;
    logic                 rd_is_first;
    logic                 rd_is_last;
    logic                 key_hit;
    logic                 scan_hit;
    logic                 scan_miss_end;

    assign cur_key       = $signed(rd_data_reg[EW-1:DW]);
    assign cur_val       = $signed(rd_data_reg[DW-1:0]);
    assign rd_is_first   = (rd_idx_reg == '0);
    assign rd_is_last    = (rd_idx_reg == n_reg - NW'(1));
    assign key_hit       = !rd_is_first && (query_reg >= prev_key_reg) && (query_reg < cur_key);
    assign scan_hit      = rd_vld_reg && key_hit;
    assign scan_miss_end = rd_vld_reg && rd_is_last && !key_hit;
    assign base_key      = rd_is_first ? cur_key : first_key_reg;
    assign base_val      = rd_is_first ? cur_val : first_val_reg;
    assign miss_val      = (query_reg < base_key) ? base_val : cur_val;
    assign cnt_zero      = (cnt_reg == '0);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    if ((in_req == pli_pkg::REQ_LOAD) || (n_eff == '0))
                    begin
                        state_next = pli_pkg::ST_DONE;
                    end
                    else
                    begin
                        state_next = pli_pkg::ST_SCAN;
                    end
                end
            end
            pli_pkg::ST_SCAN:
            begin
                if (scan_hit)
                begin
                    state_next = pli_pkg::ST_PREP;
                end
                else if (scan_miss_end)
                begin
                    state_next = pli_pkg::ST_DONE;
                end
            end
            pli_pkg::ST_PREP:
            begin
                state_next = pli_pkg::ST_MUL;
            end
            pli_pkg::ST_MUL:
            begin
                if (cnt_zero)
                begin
                    state_next = pli_pkg::ST_DIV;
                end
            end
            pli_pkg::ST_DIV:
            begin
                if (cnt_zero)
                begin
                    state_next = pli_pkg::ST_SUM;
                end
            end
            pli_pkg::ST_SUM:
            begin
                state_next = pli_pkg::ST_DONE;
            end
            pli_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = pli_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = pli_pkg::ST_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        s_axis_tready = 1'b0;
        issue_en      = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            pli_pkg::ST_IDLE:
            begin
                s_axis_tready = 1'b1;
            end
            pli_pkg::ST_SCAN:
            begin
                issue_en = (issue_reg < n_reg);
            end
            pli_pkg::ST_DONE:
            begin
                out_load = !out_valid_reg || m_axis_tready;
            end
            default:
            begin
                s_axis_tready = 1'b0;
            end
        endcase
    end

    // one bit per cycle: shift-add multiply, then restoring divide
    logic [DW:0] mul_sum;
    logic [DW:0] div_trial;
    logic [DW:0] div_diff;
    logic        div_ge;

    assign mul_sum   = {1'b0, acc_reg} + (lo_reg[0] ? {1'b0, mag_reg} : '0);
    assign div_trial = {acc_reg, lo_reg[DW-1]};
    assign div_diff  = div_trial - {1'b0, den_reg};
    assign div_ge    = (div_trial >= {1'b0, den_reg});

    always_comb
    begin
        acc_next = acc_reg;
        lo_next  = lo_reg;
        case (state_reg)
            pli_pkg::ST_MUL:
            begin
                acc_next = mul_sum[DW:1];
                lo_next  = {mul_sum[0], lo_reg[DW-1:1]};
            end
            pli_pkg::ST_DIV:
            begin
                acc_next = div_ge ? div_diff[DW-1:0] : div_trial[DW-1:0];
                lo_next  = {lo_reg[DW-2:0], div_ge};
            end
            default:
            begin
                acc_next = acc_reg;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= pli_pkg::ST_IDLE;
            entries_used_reg <= '0;
            issue_reg        <= '0;
            rd_vld_reg       <= 1'b0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            rd_vld_reg <= issue_en;
            if (cfg_valid)
            begin
                entries_used_reg <= cfg_data;
            end
            if (in_fire)
            begin
                issue_reg <= '0;
            end
            else if (issue_en)
            begin
                issue_reg <= issue_reg + NW'(1);
            end
            if (state_reg == pli_pkg::ST_PREP)
            begin
                cnt_reg <= CW'(DW - 1);
            end
            else if ((state_reg == pli_pkg::ST_MUL) || (state_reg == pli_pkg::ST_DIV))
            begin
                cnt_reg <= cnt_zero ? CW'(DW - 1) : cnt_reg - CW'(1);
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // table write and registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[AW'(in_index)] <= {in_key, in_value};
        end
        if (issue_en)
        begin
            rd_data_reg <= mem[issue_reg[AW-1:0]];
        end
    end

    // request capture and scan bookkeeping
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            query_reg <= in_query;
            n_reg     <= n_eff;
            res_reg   <= '0;
            if (in_req == pli_pkg::REQ_LOAD)
            begin
                status_reg <= idx_ok ? pli_pkg::STATUS_OK : pli_pkg::STATUS_RANGE;
            end
            else if (n_eff == '0)
            begin
                status_reg <= pli_pkg::STATUS_EMPTY;
            end
            else
            begin
                status_reg <= pli_pkg::STATUS_OK;
            end
        end
        if (issue_en)
        begin
            rd_idx_reg <= issue_reg;
        end
        if ((state_reg == pli_pkg::ST_SCAN) && rd_vld_reg)
        begin
            prev_key_reg <= cur_key;
            prev_val_reg <= cur_val;
            if (rd_is_first)
            begin
                first_key_reg <= cur_key;
                first_val_reg <= cur_val;
            end
        end
        // segment found: operands for the multiply and divide
        if ((state_reg == pli_pkg::ST_SCAN) && scan_hit)
        begin
            den_reg      <= DW'(cur_key - prev_key_reg);
            dv_reg       <= (DW + 1)'(cur_val) - (DW + 1)'(prev_val_reg);
            base_val_reg <= prev_val_reg;
        end
        // no segment: clamp to an end value
        if ((state_reg == pli_pkg::ST_SCAN) && scan_miss_end)
        begin
            res_reg <= miss_val;
        end
        // magnitude and sign of the value step
        if (state_reg == pli_pkg::ST_PREP)
        begin
            neg_reg <= dv_reg[DW];
            mag_reg <= dv_reg[DW] ? DW'(-dv_reg) : DW'(dv_reg);
        end
        // multiplier and dividend share acc/lo
        if ((state_reg == pli_pkg::ST_SCAN) && scan_hit)
        begin
            acc_reg <= '0;
            lo_reg  <= DW'(query_reg - prev_key_reg);
        end
        else
        begin
            acc_reg <= acc_next;
            lo_reg  <= lo_next;
        end
        if (state_reg == pli_pkg::ST_SUM)
        begin
            res_reg <= neg_reg ? DW'(base_val_reg) - lo_reg : DW'(base_val_reg) + lo_reg;
        end
        if (out_load)
        begin
            out_data_reg   <= res_reg;
            out_status_reg <= status_reg;
        end
    end

    // port drive
    assign cfg_ready     = 1'b1;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OUT_W'(out_data_reg);
    assign m_axis_tuser  = out_status_reg;

endmodule

// ----- hdl/pli_checker.sv -----
// ----------------------------------------------------------------------------
// pli_port_checks
// port-level checks on the interpolator, bound to the top level
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pli_port_checks #(
    parameter int DATA_WIDTH = 32,
    localparam int OUT_W = ((DATA_WIDTH + 7) / 8) * 8
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [OUT_W-1:0]              m_axis_tdata,
    input logic [pli_pkg::STATUS_W-1:0]  m_axis_tuser
);

    logic [OUT_W+pli_pkg::STATUS_W-1:0] out_beat;
    logic                               out_stall;
    logic                               status_known;
    logic                               error_beat;

    // result beat contents and stall/error flags
    assign out_beat     = {m_axis_tdata, m_axis_tuser};
    assign out_stall    = m_axis_tvalid && !m_axis_tready;
    assign status_known = (m_axis_tuser == pli_pkg::STATUS_OK) ||
                          (m_axis_tuser == pli_pkg::STATUS_EMPTY) ||
                          (m_axis_tuser == pli_pkg::STATUS_RANGE);
    assign error_beat   = m_axis_tvalid && (m_axis_tuser != pli_pkg::STATUS_OK);

    // a stalled result beat stays put
    `PLI_ASSERT_NXT(a_out_hold, clk, rst_n, out_stall, m_axis_tvalid && $stable(out_beat))

    // no accept right after an accept
    `PLI_ASSERT_NXT(a_one_in_flight, clk, rst_n, s_axis_tvalid && s_axis_tready, !s_axis_tready)

    // only defined status codes leave the block
    `PLI_ASSERT_IMP(a_status_known, clk, rst_n, m_axis_tvalid, status_known)

    // error beats carry zero data
    `PLI_ASSERT_IMP(a_error_zero, clk, rst_n, error_beat, m_axis_tdata == '0)

endmodule

bind piecewise_linear_interpolator pli_port_checks #(
    .DATA_WIDTH(DATA_WIDTH)
) u_pli_port_checks (.*);
